[src/rta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pkg: shared types and constants of the route table with aging
// Mode and status codes, register indexes, the stored entry layout, the
// store control group and the link metric function.
// ----------------------------------------------------------------------------
package rta_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 32;

  // Field widths
  localparam int NODE_W  = 16;
  localparam int HOPS_W  = 8;
  localparam int SIG_W   = 8;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 6;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 1;

  // Metric width: signed 8 bit minus up to 255 * 10
  localparam int METRIC_W = 13;

  // Saturation limit of the prune count
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_LOCAL_ID      = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_STALE_TIMEOUT = 1'b1;

  // Reset values of the registers
  localparam logic [NODE_W-1:0] LOCAL_ID_RST      = '0;
  localparam logic [TIME_W-1:0] STALE_TIMEOUT_RST = 32'd30000;

  // Transaction modes (the fourth code has no meaning)
  localparam logic [1:0] MODE_BEACON = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_PRUNE  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SELF = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_MISS = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } rta_state_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [NODE_W-1:0] key;
    logic [NODE_W-1:0] next_hop;
    logic [HOPS_W-1:0] hops;
    logic [SIG_W-1:0]  signal;
    logic [TIME_W-1:0] stamp;
  } rta_entry_t;

  // Control group from the sequencer to the entry store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } rta_ctl_t;

  // Link metric: signal - 10 * hops, hop weight built from two shifts
  function automatic logic signed [METRIC_W-1:0] link_metric(
    input logic [SIG_W-1:0]  sig,
    input logic [HOPS_W-1:0] hops
  );
    logic signed [METRIC_W-1:0] sig_x;
    logic [METRIC_W-2:0]        weight;
    sig_x  = METRIC_W'(signed'(sig));
    weight = {1'b0, hops, 3'b000} + {3'b000, hops, 1'b0};
    return sig_x - signed'({1'b0, weight});
  endfunction

endpackage

[src/route_table_with_aging.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_table_with_aging: neighbor route table with timeout aging
// Beacons insert or refresh a route keyed by node id, lookups return the
// next hop, prunes drop entries older than the stale timeout.
//
//   channel   handshake             payload
//   -------   -------------------   ----------------------------------------
//   input     start & !busy         in_mode, in_sender_node, in_hop_total,
//                                   in_signal_strength, in_wanted_dest,
//                                   in_now_ms
//   result    out_valid (1 cycle)   out_status, out_found, out_next_hop,
//                                   out_removed_count
//   config    cfg_valid & cfg_ready cfg_index, cfg_data
//
// A beacon, lookup or prune goes from accept through the scan state, which
// reads every entry in turn, the last state, which compares the last entry,
// the commit state and the strobe. Entries pass one per cycle through a
// single compare unit.
// A beacon from this node or an unused mode skips the pass to the commit state.
// busy rises after accept and drops in the strobe cycle, so the next
// transaction can be taken at the edge that ends the strobe.
// Reset is synchronous: it clears the valid flags and the registers, with no
// clearing pass. The receiver cannot stall results; cfg_ready is always high.
// ----------------------------------------------------------------------------
module route_table_with_aging #(
  parameter int TABLE_ENTRIES = rta_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [rta_pkg::NODE_W-1:0]  in_sender_node,
  input  logic [rta_pkg::HOPS_W-1:0]  in_hop_total,
  input  logic signed [rta_pkg::SIG_W-1:0] in_signal_strength,
  input  logic [rta_pkg::NODE_W-1:0]  in_wanted_dest,
  input  logic [rta_pkg::TIME_W-1:0]  in_now_ms,
  // result channel
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic                        out_found,
  output logic [rta_pkg::NODE_W-1:0]  out_next_hop,
  output logic [rta_pkg::CNT_W-1:0]   out_removed_count,
  // configuration port
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rta_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [rta_pkg::CFG_W-1:0]   cfg_data
);
  import rta_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  rta_state_t state_r, state_nxt;

  // configuration registers
  logic [NODE_W-1:0] local_id_r;
  logic [TIME_W-1:0] timeout_r;

  // latched transaction
  logic [1:0]        mode_r;
  logic [NODE_W-1:0] key_r;
  logic [HOPS_W-1:0] hops_r;
  logic [SIG_W-1:0]  sig_r;
  logic [TIME_W-1:0] now_r;
  logic              self_r;

  // scan state
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_on_r;
  logic              hit_r;
  logic              upd_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [NODE_W-1:0] hop_r;
  logic              free_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [CNT_W-1:0]  cnt_r;

  // result registers
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_found_r;
  logic [NODE_W-1:0] out_next_hop_r;
  logic [CNT_W-1:0]  out_removed_r;

  // store interface
  rta_ctl_t          ctl;
  logic [IDX_W-1:0]  wr_idx;
  rta_entry_t        wr_ent;
  rta_entry_t        rd_ent;
  logic              cmp_vld;

  // compare unit
  logic              accept;
  logic              skip;
  logic              hit_now;
  logic              free_now;
  logic              stale;
  logic              metric_ge;
  logic [TIME_W-1:0] age;

  // result of the commit cycle
  logic [1:0]        res_status;
  logic              res_found;
  logic [NODE_W-1:0] res_next_hop;
  logic [CNT_W-1:0]  res_removed;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // no table pass for a beacon from self or an unused mode
  assign skip = !((in_mode == MODE_LOOKUP) || (in_mode == MODE_PRUNE) ||
                  ((in_mode == MODE_BEACON) && (in_sender_node != local_id_r)));

  // entry store
  rta_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_idx  (idx_r),
    .cmp_idx (cmp_idx_r),
    .wr_idx  (wr_idx),
    .wr_ent  (wr_ent),
    .rd_ent  (rd_ent),
    .cmp_vld (cmp_vld)
  );

  // shared compare unit: key match, age test, metric test on the entry read
  assign age       = now_r - rd_ent.stamp;
  assign hit_now   = cmp_on_r && cmp_vld && (rd_ent.key == key_r);
  assign free_now  = cmp_on_r && !cmp_vld;
  assign stale     = cmp_on_r && cmp_vld && (age > timeout_r);
  assign metric_ge = link_metric(sig_r, hops_r) >= link_metric(rd_ent.signal, rd_ent.hops);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_id_r <= LOCAL_ID_RST;
      timeout_r  <= STALE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOCAL_ID:      local_id_r <= cfg_data[NODE_W-1:0];
        CFG_STALE_TIMEOUT: timeout_r  <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, store control and commit result
  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    wr_idx       = free_idx_r;
    wr_ent       = '{key: key_r, next_hop: key_r, hops: hops_r, signal: sig_r,
                     stamp: now_r};
    res_status   = STAT_OK;
    res_found    = 1'b0;
    res_next_hop = '0;
    res_removed  = '0;
    ctl.clr_valid = (mode_r == MODE_PRUNE) && stale;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = skip ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.rd_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
        case (mode_r)
          MODE_BEACON: begin
            if (self_r) begin
              res_status = STAT_SELF;
            end else if (hit_r) begin
              wr_idx     = hit_idx_r;
              ctl.wr_en  = upd_r;
            end else if (free_r) begin
              ctl.wr_en     = 1'b1;
              ctl.set_valid = 1'b1;
            end else begin
              res_status = STAT_FULL;
            end
          end
          MODE_LOOKUP: begin
            if (hit_r) begin
              res_found    = 1'b1;
              res_next_hop = hop_r;
            end else begin
              res_status = STAT_MISS;
            end
          end
          MODE_PRUNE: begin
            res_removed = cnt_r;
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // scan pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_on_r <= 1'b0;
    end else begin
      cmp_on_r <= (state_r == ST_SCAN);
    end
  end

  // transaction latch and scan bookkeeping
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= (in_mode == MODE_LOOKUP) ? in_wanted_dest : in_sender_node;
      hops_r <= in_hop_total;
      sig_r  <= in_signal_strength;
      now_r  <= in_now_ms;
      self_r <= (in_sender_node == local_id_r);
      idx_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (state_r == ST_SCAN) begin
        idx_r <= idx_r + 1'b1;
      end
      // first matching entry
      if (hit_now && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
        upd_r     <= metric_ge || (rd_ent.next_hop == key_r);
        hop_r     <= rd_ent.next_hop;
      end
      // lowest free slot
      if (free_now && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
      // saturating prune count
      if ((mode_r == MODE_PRUNE) && stale && (cnt_r != COUNT_MAX)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_COMMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_COMMIT) begin
      out_status_r   <= res_status;
      out_found_r    <= res_found;
      out_next_hop_r <= res_next_hop;
      out_removed_r  <= res_removed;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found         = out_found_r;
  assign out_next_hop      = out_next_hop_r;
  assign out_removed_count = out_removed_r;

`ifndef NO_ASSERTIONS
  // a result is shown only once the block is free again
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a found route always reports plain success
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == STAT_OK && mode_r == MODE_LOOKUP))
    else $error("found flag outside a successful lookup");

  // only a prune removes entries
  a_removed_prune: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_removed_count != '0)) |-> (mode_r == MODE_PRUNE))
    else $error("removed count outside a prune");

  // table writes happen only in the commit cycle
  a_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> (state_r == ST_COMMIT && mode_r == MODE_BEACON))
    else $error("table write outside beacon commit");
`endif

endmodule

[src/rta_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_store: entry memory and valid bits
// One memory of packed entries with a registered read port and one write
// port, plus a valid flag per entry that reset clears.
// ----------------------------------------------------------------------------
module rta_store #(
  parameter int TABLE_ENTRIES = rta_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rta_pkg::rta_ctl_t    ctl,
  input  logic [IDX_W-1:0]     rd_idx,
  input  logic [IDX_W-1:0]     cmp_idx,
  input  logic [IDX_W-1:0]     wr_idx,
  input  rta_pkg::rta_entry_t  wr_ent,
  output rta_pkg::rta_entry_t  rd_ent,
  output logic                 cmp_vld
);
  import rta_pkg::*;

  rta_entry_t               mem [TABLE_ENTRIES];
  rta_entry_t               rd_ent_r;
  logic [TABLE_ENTRIES-1:0] vld_r;

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    if (ctl.rd_en) begin
      rd_ent_r <= mem[rd_idx];
    end
  end

  // Valid flags: set on insert, cleared by prune
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ctl.set_valid) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (ctl.clr_valid) begin
        vld_r[cmp_idx] <= 1'b0;
      end
    end
  end

  assign rd_ent  = rd_ent_r;
  assign cmp_vld = vld_r[cmp_idx];

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the route table with aging
// A queue of route transactions (beacons, lookups, prunes, unused-mode noise)
// feeds a clocked driver. The driver keeps a shadow route table and works out
// each expected reply when the block accepts a transaction. A clocked monitor
// compares every reply strobe with the oldest expected reply. Register
// settings change between phases while the block is idle, and idle bursts
// are inserted at random except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import rta_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int HOP_WEIGHT    = 10;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int POOL_SIZE     = 40;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 370;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // One route transaction as driven on the input ports
  typedef struct packed {
    logic [1:0]        mode;
    logic [NODE_W-1:0] sender;
    logic [HOPS_W-1:0] hops;
    logic [SIG_W-1:0]  sig;
    logic [NODE_W-1:0] dest;
    logic [TIME_W-1:0] now;
  } route_req_t;

  // One reply as seen on the result ports
  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [NODE_W-1:0] next_hop;
    logic [CNT_W-1:0]  removed;
  } route_reply_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // Block ports
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_mode = '0;
  logic [NODE_W-1:0]        in_sender_node = '0;
  logic [HOPS_W-1:0]        in_hop_total = '0;
  logic signed [SIG_W-1:0]  in_signal_strength = '0;
  logic [NODE_W-1:0]        in_wanted_dest = '0;
  logic [TIME_W-1:0]        in_now_ms = '0;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic                     out_found;
  logic [NODE_W-1:0]        out_next_hop;
  logic [CNT_W-1:0]         out_removed_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  route_table_with_aging #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_sender_node    (in_sender_node),
    .in_hop_total      (in_hop_total),
    .in_signal_strength(in_signal_strength),
    .in_wanted_dest    (in_wanted_dest),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_next_hop      (out_next_hop),
    .out_removed_count (out_removed_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Shadow registers and route table
  logic [NODE_W-1:0] my_id       = LOCAL_ID_RST;
  logic [TIME_W-1:0] aging_limit = STALE_TIMEOUT_RST;
  bit                tbl_valid [TABLE_ENTRIES];
  logic [NODE_W-1:0] tbl_key   [TABLE_ENTRIES];
  logic [NODE_W-1:0] tbl_next  [TABLE_ENTRIES];
  logic [HOPS_W-1:0] tbl_hops  [TABLE_ENTRIES];
  logic [SIG_W-1:0]  tbl_sig   [TABLE_ENTRIES];
  logic [TIME_W-1:0] tbl_stamp [TABLE_ENTRIES];

  // Transactions waiting to be driven, replies waiting to arrive
  route_req_t   route_reqs_pending [$];
  route_reply_t replies_due [$];

  // Bookkeeping
  int          fail_count = 0;
  int          replies_seen = 0;
  int          n_insert = 0, n_refresh = 0, n_full = 0, n_self = 0;
  int          n_hit = 0, n_miss = 0, n_pruned = 0, n_unused = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;

  // Link metric: signed strength minus weighted hop count
  function automatic int route_metric(logic [SIG_W-1:0] s, logic [HOPS_W-1:0] h);
    return int'($signed(s)) - int'(h) * HOP_WEIGHT;
  endfunction

  function automatic int find_route(logic [NODE_W-1:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void store_route(int i, route_req_t rq);
    tbl_key[i]   = rq.sender;
    tbl_next[i]  = rq.sender;
    tbl_hops[i]  = rq.hops;
    tbl_sig[i]   = rq.sig;
    tbl_stamp[i] = rq.now;
    tbl_valid[i] = 1'b1;
  endfunction

  // Update the shadow table with one transaction and return its reply
  function automatic route_reply_t predict_route_reply(route_req_t rq);
    route_reply_t      rp;
    int                hit;
    int                slot;
    logic [TIME_W-1:0] age;
    rp = '0;
    case (rq.mode)
      MODE_BEACON: begin
        if (rq.sender == my_id) begin
          rp.status = STAT_SELF;
          n_self++;
        end else begin
          hit = find_route(rq.sender);
          if (hit >= 0) begin
            if (route_metric(rq.sig, rq.hops) >=
                route_metric(tbl_sig[hit], tbl_hops[hit]) ||
                tbl_next[hit] == rq.sender) begin
              store_route(hit, rq);
              n_refresh++;
            end
          end else begin
            // new sender goes to the lowest free slot
            slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
              if (!tbl_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
              rp.status = STAT_FULL;
              n_full++;
            end else begin
              store_route(slot, rq);
              n_insert++;
            end
          end
        end
      end
      MODE_LOOKUP: begin
        hit = find_route(rq.dest);
        if (hit >= 0) begin
          rp.found    = 1'b1;
          rp.next_hop = tbl_next[hit];
          n_hit++;
        end else begin
          rp.status = STAT_MISS;
          n_miss++;
        end
      end
      MODE_PRUNE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            age = rq.now - tbl_stamp[i];
            if (age > aging_limit) begin
              tbl_valid[i] = 1'b0;
              if (rp.removed != COUNT_MAX) rp.removed++;
              n_pruned++;
            end
          end
        end
      end
      default: n_unused++;
    endcase
    return rp;
  endfunction

  task automatic report_fail(string what, route_reply_t exp_r, route_reply_t act_r);
    fail_count++;
    if (fail_count <= 10) begin
      $display("MISMATCH %s at cycle %0d", what, cycle_count);
      $display("  exp status=%0d found=%0d hop=%h rm=%0d",
               exp_r.status, exp_r.found, exp_r.next_hop, exp_r.removed);
      $display("  act status=%0d found=%0d hop=%h rm=%0d",
               act_r.status, act_r.found, act_r.next_hop, act_r.removed);
    end
  endtask

  // Register shadow: follows every configuration transaction
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOCAL_ID:      my_id = cfg_data[NODE_W-1:0];
        CFG_STALE_TIMEOUT: aging_limit = cfg_data;
        default: ;
      endcase
    end
  end

  // Driver: predicts on accept, then holds, idles or launches the next one
  route_req_t cur_req;
  int         gap_left = 0;
  bit         gap_thru_busy = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        replies_due = {replies_due, predict_route_reply(cur_req)};
        if (idle_on && $urandom_range(0, 3) == 0) begin
          gap_left      = $urandom_range(1, 16);
          gap_thru_busy = 1'($urandom_range(0, 1));
        end
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          if (!busy || gap_thru_busy) gap_left--;
        end else if (route_reqs_pending.size() != 0) begin
          cur_req = route_reqs_pending.pop_front();
          in_mode            <= cur_req.mode;
          in_sender_node     <= cur_req.sender;
          in_hop_total       <= cur_req.hops;
          in_signal_strength <= cur_req.sig;
          in_wanted_dest     <= cur_req.dest;
          in_now_ms          <= cur_req.now;
          start              <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every reply strobe against the oldest expected reply
  always @(posedge clk) begin
    route_reply_t act_r;
    route_reply_t exp_r;
    if (rst_n && out_valid) begin
      act_r = '{out_status, out_found, out_next_hop, out_removed_count};
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_fail("unexpected reply", '0, act_r);
      end else begin
        exp_r = replies_due.pop_front();
        if (act_r !== exp_r) report_fail("reply", exp_r, act_r);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
               replies_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_req(logic [1:0] mode, logic [NODE_W-1:0] sender,
                           logic [HOPS_W-1:0] hops, logic [SIG_W-1:0] sig,
                           logic [NODE_W-1:0] dest, logic [TIME_W-1:0] now);
    route_req_t rq;
    rq = '{mode, sender, hops, sig, dest, now};
    route_reqs_pending = {route_reqs_pending, rq};
  endtask

  task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every transaction is accepted and every reply is back
  task automatic wait_drained();
    @(negedge clk);
    while (route_reqs_pending.size() != 0 || start || replies_due.size() != 0 || busy)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Stimulus
  logic [NODE_W-1:0] key_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_ms;
  logic [NODE_W-1:0] phase_id;

  // Mostly beacons, lookups and prunes over a small key pool, some noise
  task automatic queue_random_traffic(int count);
    int                done;
    int                r;
    route_req_t        rq;
    logic [TIME_W-1:0] step_max;
    done = 0;
    step_max = (aging_limit > 32000) ? 32'd8000 : aging_limit / 4 + 8;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 4)       rq.mode = MODE_UNUSED;
      else if (r < 58) rq.mode = MODE_BEACON;
      else if (r < 84) rq.mode = MODE_LOOKUP;
      else             rq.mode = MODE_PRUNE;
      r = $urandom_range(0, 99);
      if (r < 6)       rq.sender = phase_id;
      else if (r < 88) rq.sender = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else             rq.sender = NODE_W'($urandom);
      rq.hops = $urandom_range(0, 1) ? HOPS_W'($urandom_range(0, 15))
                                     : HOPS_W'($urandom_range(0, 255));
      rq.sig  = SIG_W'($urandom);
      rq.dest = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : NODE_W'($urandom);
      // time moves forward, with an occasional wild jump (may go backward)
      if ($urandom_range(0, 39) == 0) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      rq.now = clock_ms;
      route_reqs_pending = {route_reqs_pending, rq};
      done++;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] new_tmo;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset settings (local id 0, timeout 30000)
    queue_req(MODE_BEACON, 16'h0000, 8'd5, 8'sd10, 16'h0000, 32'd100);    // from self
    queue_req(MODE_UNUSED, 16'hFFFF, 8'hFF, 8'h7F, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(MODE_LOOKUP, 16'h0000, 8'd0, 8'd0, 16'hFFFF, 32'd0);        // miss, empty
    queue_req(MODE_PRUNE, 16'h0000, 8'd0, 8'd0, 16'h0000, 32'd0);         // empty prune
    queue_req(MODE_BEACON, 16'hFFFF, 8'd0, 8'h7F, 16'h0000, 32'd0);       // slot 0
    queue_req(MODE_BEACON, 16'h0001, 8'hFF, 8'h80, 16'h0000, 32'd10);     // slot 1
    queue_req(MODE_BEACON, 16'h8000, 8'd3, 8'hD8, 16'h0000, 32'hFFFF_FFF0);
    queue_req(MODE_LOOKUP, 16'h0000, 8'd0, 8'd0, 16'hFFFF, 32'd20);
    queue_req(MODE_LOOKUP, 16'h0000, 8'd0, 8'd0, 16'h0001, 32'd20);
    queue_req(MODE_LOOKUP, 16'hFFFF, 8'd0, 8'd0, 16'h0000, 32'd20);       // miss
    // worse metric, but next hop is the sender itself: still refreshed
    queue_req(MODE_BEACON, 16'hFFFF, 8'hFF, 8'h80, 16'h0000, 32'd50);
    // age equal to the timeout stays, older ones go; wrapped stamp goes
    queue_req(MODE_PRUNE, 16'h0000, 8'd0, 8'd0, 16'h0000, 32'd30050);
    queue_req(MODE_LOOKUP, 16'h0000, 8'd0, 8'd0, 16'h0001, 32'd30050);
    queue_req(MODE_BEACON, 16'h0001, 8'd0, 8'd0, 16'h0000, 32'd30050);    // lowest free
    queue_req(MODE_BEACON, 16'h5555, 8'hAA, 8'h55, 16'h0000, 32'd30050);
    queue_req(MODE_PRUNE, 16'h0000, 8'd0, 8'd0, 16'h0000, 32'd60051);
    // age across the 2^32 wrap
    queue_req(MODE_BEACON, 16'hAAAA, 8'd1, 8'hFF, 16'h5555, 32'hFFFF_FF00);
    queue_req(MODE_PRUNE, 16'hFFFF, 8'hFF, 8'h7F, 16'hFFFF, 32'h0000_0100);
    queue_req(MODE_LOOKUP, 16'h0000, 8'd0, 8'd0, 16'hAAAA, 32'h0000_0100);
    queue_req(MODE_UNUSED, 16'h0000, 8'd0, 8'd0, 16'h0000, 32'd0);
    wait_drained();

    // Random phases, each at its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      foreach (key_pool[k]) key_pool[k] = NODE_W'($urandom);
      case (p)
        0: begin phase_id = 16'hFFFF;       new_tmo = 32'd0;          clock_ms = 32'h1000; end
        1: begin phase_id = key_pool[0];    new_tmo = 32'hFFFF_FFFF;  clock_ms = 32'hFFFF_0000; end
        2: begin phase_id = NODE_W'($urandom); new_tmo = $urandom_range(500, 5000);
                 clock_ms = $urandom; end
        3: begin phase_id = key_pool[0];    new_tmo = STALE_TIMEOUT_RST; clock_ms = $urandom; end
        default: begin
          phase_id = 16'h0000;  new_tmo = $urandom_range(1000, 3000);  clock_ms = $urandom;
        end
      endcase
      if (p == RAND_PHASES - 1) idle_on = 1'b0;
      write_cfg(CFG_LOCAL_ID, CFG_W'(phase_id));
      write_cfg(CFG_STALE_TIMEOUT, new_tmo);
      @(negedge clk);
      queue_random_traffic(PHASE_ITEMS);
      wait_drained();
    end

    if (replies_due.size() != 0) report_fail("missing reply", replies_due[0], '0);
    $display("Run covered %0d replies over %0d register settings", replies_seen,
             RAND_PHASES + 1);
    $display("  %0d inserts, %0d refreshes, %0d full-table drops, %0d self beacons",
             n_insert, n_refresh, n_full, n_self);
    $display("  lookups %0d hit / %0d miss, %0d aged out, %0d unused-mode, %0d failures",
             n_hit, n_miss, n_pruned, n_unused, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
src/rta_pkg.sv
src/rta_store.sv
src/route_table_with_aging.sv
sim/tb_top.sv
